### src/tac_pkg.sv
// Shared types, constants and microcode table for the tiny accumulator CPU.
package tac_pkg;

  localparam int MEM_WORDS = 256;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int DATA_W    = 8;
  localparam int PC_W      = 9;

  localparam logic [ADDR_W-1:0] RESERVED_ADDR = '0;
  localparam logic [DATA_W-1:0] START_RESET   = 8'd1;
  localparam logic [DATA_W-1:0] CEIL_RESET    = 8'd253;

  // commands
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_STEP    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // configuration register indexes
  localparam logic CFG_START = 1'b0;
  localparam logic CFG_CEIL  = 1'b1;

  // opcodes
  localparam logic [DATA_W-1:0] OP_HALT  = 8'd0;
  localparam logic [DATA_W-1:0] OP_LDI   = 8'd1;
  localparam logic [DATA_W-1:0] OP_LDB   = 8'd2;
  localparam logic [DATA_W-1:0] OP_ADD   = 8'd3;
  localparam logic [DATA_W-1:0] OP_BEEP  = 8'd4;
  localparam logic [DATA_W-1:0] OP_STORE = 8'd5;
  localparam logic [DATA_W-1:0] OP_PRINT = 8'd6;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_BEEP  = 2'd1,
    EV_PRINT = 2'd2,
    EV_HALT  = 2'd3
  } tac_event_t;

  typedef enum logic [1:0] {
    ASEL_PC   = 2'd0,
    ASEL_ZERO = 2'd1,
    ASEL_OPR  = 2'd2,
    ASEL_IN   = 2'd3
  } tac_asel_t;

  typedef enum logic [1:0] {
    WSEL_DATA  = 2'd0,
    WSEL_RDATA = 2'd1,
    WSEL_ACC   = 2'd2
  } tac_wsel_t;

  typedef enum logic [1:0] {
    SEQ_GOTO     = 2'd0,
    SEQ_DISPATCH = 2'd1,
    SEQ_END      = 2'd2
  } tac_seq_t;

  typedef logic [4:0] tac_step_t;

  localparam tac_step_t STEP_LOAD    = 5'd0;
  localparam tac_step_t STEP_RESTART = 5'd1;
  localparam tac_step_t STEP_NOP     = 5'd2;
  localparam tac_step_t STEP_FETCH   = 5'd3;
  localparam tac_step_t STEP_COPY    = 5'd4;
  localparam tac_step_t STEP_HALT    = 5'd5;
  localparam tac_step_t STEP_RD_ACC  = 5'd6;
  localparam tac_step_t STEP_LD_ACC  = 5'd7;
  localparam tac_step_t STEP_RD_OPR  = 5'd8;
  localparam tac_step_t STEP_LD_OPR  = 5'd9;
  localparam tac_step_t STEP_ADD     = 5'd10;
  localparam tac_step_t STEP_BEEP    = 5'd11;
  localparam tac_step_t STEP_RD_ST   = 5'd12;
  localparam tac_step_t STEP_LD_ST   = 5'd13;
  localparam tac_step_t STEP_ST      = 5'd14;
  localparam tac_step_t STEP_RD_PR   = 5'd15;
  localparam tac_step_t STEP_LD_PR   = 5'd16;
  localparam tac_step_t STEP_RD_IND  = 5'd17;
  localparam tac_step_t STEP_PRINT   = 5'd18;

  typedef struct packed {
    tac_asel_t  asel;
    logic       mem_en;
    logic       mem_we;
    tac_wsel_t  wsel;
    logic       pc_inc;
    logic       restart;
    logic       chk_ceil;
    logic       set_halt;
    logic       ld_acc;
    logic       acc_add;
    logic       ld_opr;
    logic       ld_val;
    tac_event_t ev_set;
    tac_seq_t   seq;
    tac_step_t  next;
  } tac_uword_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } tac_mem_req_t;

  // read the next program byte and advance the counter
  function automatic tac_uword_t uw_read_pc(input tac_step_t nxt);
    tac_uword_t w;
    w        = '0;
    w.asel   = ASEL_PC;
    w.mem_en = 1'b1;
    w.pc_inc = 1'b1;
    w.seq    = SEQ_GOTO;
    w.next   = nxt;
    return w;
  endfunction

  function automatic tac_uword_t ucode(input tac_step_t step);
    tac_uword_t w;
    w     = '0;
    w.seq = SEQ_END;
    unique case (step)
      STEP_LOAD: begin
        w.asel   = ASEL_IN;
        w.mem_en = 1'b1;
        w.mem_we = 1'b1;
        w.wsel   = WSEL_DATA;
      end
      STEP_RESTART: w.restart = 1'b1;
      STEP_NOP:     w.seq = SEQ_END;
      STEP_FETCH:   w = uw_read_pc(STEP_COPY);
      STEP_COPY: begin
        // opcode goes to the reserved byte; branch on it and on the ceiling
        w.asel     = ASEL_ZERO;
        w.mem_en   = 1'b1;
        w.mem_we   = 1'b1;
        w.wsel     = WSEL_RDATA;
        w.chk_ceil = 1'b1;
        w.seq      = SEQ_DISPATCH;
      end
      STEP_HALT: begin
        w.set_halt = 1'b1;
        w.ev_set   = EV_HALT;
      end
      STEP_RD_ACC: w = uw_read_pc(STEP_LD_ACC);
      STEP_LD_ACC: begin
        w        = uw_read_pc(STEP_LD_OPR);
        w.ld_acc = 1'b1;
      end
      STEP_RD_OPR: w = uw_read_pc(STEP_LD_OPR);
      STEP_LD_OPR: begin
        w.ld_opr = 1'b1;
        w.seq    = SEQ_GOTO;
        w.next   = STEP_ADD;
      end
      STEP_ADD:   w.acc_add = 1'b1;
      STEP_BEEP:  w.ev_set = EV_BEEP;
      STEP_RD_ST: w = uw_read_pc(STEP_LD_ST);
      STEP_LD_ST: begin
        w.ld_opr = 1'b1;
        w.seq    = SEQ_GOTO;
        w.next   = STEP_ST;
      end
      STEP_ST: begin
        w.asel   = ASEL_OPR;
        w.mem_en = 1'b1;
        w.mem_we = 1'b1;
        w.wsel   = WSEL_ACC;
      end
      STEP_RD_PR: w = uw_read_pc(STEP_LD_PR);
      STEP_LD_PR: begin
        w.ld_opr = 1'b1;
        w.seq    = SEQ_GOTO;
        w.next   = STEP_RD_IND;
      end
      STEP_RD_IND: begin
        w.asel   = ASEL_OPR;
        w.mem_en = 1'b1;
        w.seq    = SEQ_GOTO;
        w.next   = STEP_PRINT;
      end
      STEP_PRINT: begin
        w.ld_acc = 1'b1;
        w.ld_val = 1'b1;
        w.ev_set = EV_PRINT;
      end
      default: w.seq = SEQ_END;
    endcase
    return w;
  endfunction

  function automatic tac_step_t dispatch(input logic [DATA_W-1:0] op);
    tac_step_t s;
    unique case (op)
      OP_HALT:  s = STEP_HALT;
      OP_LDI:   s = STEP_RD_ACC;
      OP_LDB:   s = STEP_RD_OPR;
      OP_ADD:   s = STEP_ADD;
      OP_BEEP:  s = STEP_BEEP;
      OP_STORE: s = STEP_RD_ST;
      OP_PRINT: s = STEP_RD_PR;
      default:  s = STEP_NOP;
    endcase
    return s;
  endfunction

  function automatic tac_step_t entry(input logic [1:0] c, input logic halt);
    tac_step_t s;
    unique case (c)
      CMD_LOAD:    s = STEP_LOAD;
      CMD_STEP:    s = halt ? STEP_NOP : STEP_FETCH;
      CMD_RESTART: s = STEP_RESTART;
      default:     s = STEP_NOP;
    endcase
    return s;
  endfunction

endpackage

### src/tac_ram.sv
// Generic single-port RAM with registered read.
module tac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### src/tac_mem.sv
// CPU memory: RAM plus per-byte written flags so unwritten bytes read as zero.
module tac_mem (
  input  logic                       clk,
  input  logic                       rst,
  input  tac_pkg::tac_mem_req_t      req,
  output logic [tac_pkg::DATA_W-1:0] rdata
);

  logic [tac_pkg::MEM_WORDS-1:0] written;
  logic                          rd_written;
  logic [tac_pkg::DATA_W-1:0]    ram_q;

  tac_ram #(
    .WIDTH(tac_pkg::DATA_W),
    .DEPTH(tac_pkg::MEM_WORDS)
  ) u_ram (
    .clk  (clk),
    .en   (req.en),
    .we   (req.we),
    .addr (req.addr),
    .wdata(req.wdata),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else if (req.en) begin
      if (req.we) begin
        written[req.addr] <= 1'b1;
      end else begin
        rd_written <= written[req.addr];
      end
    end
  end

  assign rdata = rd_written ? ram_q : '0;

endmodule

### src/tiny_accumulator_cpu_step.sv
// Tiny accumulator CPU advanced one command item at a time; one result item per command.
// Each item runs a short microprogram, one control word per cycle, over a single-port
// 256-byte memory, and then forms its result in a finish step. A load or restart command
// runs its own microcode step, an unused one a no-op step; an execute command runs a
// fetch, an opcode copy, then the steps for operand and indirect accesses (print and
// load immediate being longest), or only a no-op step when the machine is already
// halted. The single memory port, one access per step, sets each microprogram's length;
// a stalled result adds its stall to the finish of the following item. The result waits
// in an output register, so the next item is taken while it is still unclaimed. Memory
// reads as zero after reset through per-byte written flags; there is no clearing pass.
module tiny_accumulator_cpu_step (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [1:0]                 cmd,
  input  logic [tac_pkg::ADDR_W-1:0] address,
  input  logic [tac_pkg::DATA_W-1:0] data,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [1:0]                 event_res,
  output logic [tac_pkg::DATA_W-1:0] value,
  output logic [tac_pkg::PC_W-1:0]   counter,
  output logic                       halted,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [tac_pkg::DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t                     state;
  tac_pkg::tac_step_t         upc;
  tac_pkg::tac_uword_t        uw;
  tac_pkg::tac_mem_req_t      mem_req;
  tac_pkg::tac_event_t        ev;
  logic [tac_pkg::PC_W-1:0]   pc;
  logic [tac_pkg::DATA_W-1:0] acc;
  logic [tac_pkg::DATA_W-1:0] opr;
  logic                       halt;
  logic [tac_pkg::DATA_W-1:0] val;
  logic                       exec;
  logic [tac_pkg::ADDR_W-1:0] addr_hold;
  logic [tac_pkg::DATA_W-1:0] data_hold;
  logic [tac_pkg::DATA_W-1:0] start_addr;
  logic [tac_pkg::DATA_W-1:0] ceiling;
  logic [tac_pkg::DATA_W-1:0] rd;
  logic                       past_ceil;
  logic                       accept;
  logic                       out_free;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign cfg_ready  = 1'b1;
  assign uw         = tac_pkg::ucode(upc);
  assign past_ceil  = pc > {1'b0, ceiling};

  always_comb begin
    mem_req.en = (state == ST_RUN) && uw.mem_en;
    mem_req.we = uw.mem_we;
    unique case (uw.asel)
      tac_pkg::ASEL_PC:   mem_req.addr = pc[tac_pkg::ADDR_W-1:0];
      tac_pkg::ASEL_ZERO: mem_req.addr = tac_pkg::RESERVED_ADDR;
      tac_pkg::ASEL_OPR:  mem_req.addr = opr;
      tac_pkg::ASEL_IN:   mem_req.addr = addr_hold;
    endcase
    unique case (uw.wsel)
      tac_pkg::WSEL_DATA:  mem_req.wdata = data_hold;
      tac_pkg::WSEL_RDATA: mem_req.wdata = rd;
      default:             mem_req.wdata = acc;
    endcase
  end

  tac_mem u_mem (
    .clk  (clk),
    .rst  (rst),
    .req  (mem_req),
    .rdata(rd)
  );

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      upc          <= tac_pkg::STEP_NOP;
      pc           <= {1'b0, tac_pkg::START_RESET};
      acc          <= '0;
      opr          <= '0;
      halt         <= 1'b0;
      exec         <= 1'b0;
      ev           <= tac_pkg::EV_NONE;
      start_addr   <= tac_pkg::START_RESET;
      ceiling      <= tac_pkg::CEIL_RESET;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tac_pkg::CFG_START: start_addr <= cfg_data;
          tac_pkg::CFG_CEIL:  ceiling    <= cfg_data;
        endcase
      end
      if (state == ST_FIN && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            upc   <= tac_pkg::entry(cmd, halt);
            exec  <= (cmd == tac_pkg::CMD_STEP);
            ev    <= tac_pkg::EV_NONE;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (uw.restart) begin
            pc <= {1'b0, start_addr};
          end else if (uw.pc_inc) begin
            pc <= pc + 9'd1;
          end
          if (uw.restart) begin
            halt <= 1'b0;
          end else if (uw.set_halt || (uw.chk_ceil && past_ceil)) begin
            halt <= 1'b1;
          end
          if (uw.ld_acc) begin
            acc <= rd;
          end else if (uw.acc_add) begin
            acc <= acc + opr;
          end
          if (uw.ld_opr) begin
            opr <= rd;
          end
          if (uw.ev_set != tac_pkg::EV_NONE) begin
            ev <= uw.ev_set;
          end
          unique case (uw.seq)
            tac_pkg::SEQ_GOTO:     upc <= uw.next;
            // past the ceiling the opcode is copied but not run
            tac_pkg::SEQ_DISPATCH: upc <= past_ceil ? tac_pkg::STEP_NOP : tac_pkg::dispatch(rd);
            default:               state <= ST_FIN;
          endcase
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_hold <= address;
      data_hold <= data;
      val       <= '0;
    end else if (state == ST_RUN && uw.ld_val) begin
      val <= rd;
    end
    if (state == ST_FIN && out_free) begin
      event_res <= (exec && halt) ? tac_pkg::EV_HALT : ev;
      value     <= val;
      counter   <= pc;
      halted    <= halt;
    end
  end

`ifndef NO_ASSERTIONS
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_FIN)
    else $error("result raised outside finish step");

  a_value_only_on_print: assert property (@(posedge clk) disable iff (rst)
    result_valid && event_res != tac_pkg::EV_PRINT |-> value == '0)
    else $error("value non-zero without print event");

  a_halt_event_halted: assert property (@(posedge clk) disable iff (rst)
    result_valid && event_res == tac_pkg::EV_HALT |-> halted)
    else $error("halt event while not halted");

  a_restart_reloads: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN && uw.restart |=> !halt && pc == {1'b0, $past(start_addr)})
    else $error("restart did not reload counter and clear halt");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for the tiny accumulator CPU: directed programs, then random ones.
`timescale 1ns / 100ps

module tb;

  localparam int          ITEM_TARGET   = 1700;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          TIMEOUT_NS    = 12_000_000;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [7:0]  SHARED_BASE   = 8'h80;

  typedef struct {
    tac_pkg::tac_event_t ev;
    logic [7:0]          val;
    logic [8:0]          pc;
    logic                halt;
  } cpu_result_t;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  logic [1:0] cmd          = tac_pkg::CMD_LOAD;
  logic [7:0] address      = '0;
  logic [7:0] data         = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [1:0] event_res;
  logic [7:0] value;
  logic [8:0] counter;
  logic       halted;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic       cfg_index    = tac_pkg::CFG_START;
  logic [7:0] cfg_data     = '0;

  // CPU image kept by the testbench
  logic [7:0] mem_img [tac_pkg::MEM_WORDS];
  logic [8:0] pc_m;
  logic [7:0] acc_m;
  logic [7:0] opr_m;
  logic       halt_m;
  logic [7:0] start_m = tac_pkg::START_RESET;
  logic [7:0] ceil_m  = tac_pkg::CEIL_RESET;

  cpu_result_t pending_cpu_results [$];

  int  errors        = 0;
  int  items_sent    = 0;
  int  steps_sent    = 0;
  int  results_seen  = 0;
  int  cfg_sets      = 0;
  int  stall_left    = 0;
  bit  idle_on       = 1'b1;

  tiny_accumulator_cpu_step u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .address      (address),
    .data         (data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .event_res    (event_res),
    .value        (value),
    .counter      (counter),
    .halted       (halted),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // reads the byte at the counter and moves the counter on
  function automatic logic [7:0] fetch_byte();
    logic [7:0] b;
    b    = mem_img[pc_m[7:0]];
    pc_m = pc_m + 9'd1;
    return b;
  endfunction

  function automatic cpu_result_t cpu_model_step(input logic [1:0] c, input logic [7:0] a,
                                                 input logic [7:0] d);
    cpu_result_t r;
    logic [7:0]  op;
    r.ev  = tac_pkg::EV_NONE;
    r.val = '0;
    case (c)
      tac_pkg::CMD_LOAD: mem_img[a] = d;
      tac_pkg::CMD_RESTART: begin
        halt_m = 1'b0;
        pc_m   = {1'b0, start_m};
      end
      tac_pkg::CMD_STEP: begin
        if (halt_m) begin
          r.ev = tac_pkg::EV_HALT;
        end else begin
          op = fetch_byte();
          if (pc_m > {1'b0, ceil_m}) halt_m = 1'b1;
          mem_img[tac_pkg::RESERVED_ADDR] = op;
          if (halt_m) begin
            r.ev = tac_pkg::EV_HALT;
          end else begin
            case (op)
              tac_pkg::OP_HALT: begin
                halt_m = 1'b1;
                r.ev   = tac_pkg::EV_HALT;
              end
              // load immediate runs on into load-operand and add
              tac_pkg::OP_LDI: begin
                acc_m = fetch_byte();
                opr_m = fetch_byte();
                acc_m = acc_m + opr_m;
              end
              tac_pkg::OP_LDB: begin
                opr_m = fetch_byte();
                acc_m = acc_m + opr_m;
              end
              tac_pkg::OP_ADD:   acc_m = acc_m + opr_m;
              tac_pkg::OP_BEEP:  r.ev = tac_pkg::EV_BEEP;
              tac_pkg::OP_STORE: begin
                opr_m          = fetch_byte();
                mem_img[opr_m] = acc_m;
              end
              tac_pkg::OP_PRINT: begin
                opr_m = fetch_byte();
                acc_m = mem_img[opr_m];
                r.ev  = tac_pkg::EV_PRINT;
                r.val = acc_m;
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
    r.pc   = pc_m;
    r.halt = halt_m;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_opcode();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return tac_pkg::OP_HALT;
    if (r >= 18) return 8'($urandom_range(tac_pkg::OP_PRINT + 1, 255));
    case (r % 6)
      0:       return tac_pkg::OP_LDI;
      1:       return tac_pkg::OP_LDB;
      2:       return tac_pkg::OP_ADD;
      3:       return tac_pkg::OP_BEEP;
      4:       return tac_pkg::OP_STORE;
      default: return tac_pkg::OP_PRINT;
    endcase
  endfunction

  function automatic int operand_bytes(input logic [7:0] op);
    case (op)
      tac_pkg::OP_LDI:                                     return 2;
      tac_pkg::OP_LDB, tac_pkg::OP_STORE, tac_pkg::OP_PRINT: return 1;
      default:                                             return 0;
    endcase
  endfunction

  // stores and prints often share a small window so printed bytes were stored
  function automatic logic [7:0] pick_operand(input logic [7:0] op);
    int r;
    r = $urandom_range(0, 9);
    if ((op == tac_pkg::OP_STORE || op == tac_pkg::OP_PRINT) && r < 5)
      return SHARED_BASE + 8'($urandom_range(0, 7));
    if (r == 5) return 8'h00;
    if (r == 6) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_start();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_ceiling();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1, 2, 3: return 8'hFF;
      4:       return 8'($urandom);
      default: return 8'($urandom_range(200, 255));
    endcase
  endfunction

  task automatic send_item(input logic [1:0] c, input logic [7:0] a, input logic [7:0] d);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd        <= c;
    address    <= a;
    data       <= d;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_cpu_results.push_back(cpu_model_step(c, a, d));
    items_sent++;
    if (c == tac_pkg::CMD_STEP) steps_sent++;
  endtask

  // hold off until every result is back and the block has gone quiet
  task automatic drain();
    item_valid <= 1'b0;
    while (pending_cpu_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] start_v, input logic [7:0] ceil_v);
    cfg_valid <= 1'b1;
    cfg_index <= tac_pkg::CFG_START;
    cfg_data  <= start_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    start_m   = start_v;
    cfg_index <= tac_pkg::CFG_CEIL;
    cfg_data  <= ceil_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ceil_m    = ceil_v;
    cfg_valid <= 1'b0;
    cfg_sets++;
  endtask

  task automatic check_field(input string name, input logic [8:0] exp_v,
                             input logic [8:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : result_checker
    cpu_result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_cpu_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, event %0d counter %0d", $time, event_res, counter);
      end else begin
        exp_r = pending_cpu_results.pop_front();
        check_field("event", 9'(exp_r.ev), 9'(event_res));
        check_field("value", 9'(exp_r.val), 9'(value));
        check_field("counter", exp_r.pc, counter);
        check_field("halted", 9'(exp_r.halt), 9'(halted));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || !idle_on) begin
      result_stall <= 1'b0;
      stall_left   = 0;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // zeroed memory: first fetch is a halt; then a step while halted and the spare command
  task automatic test_reset_state();
    send_item(tac_pkg::CMD_STEP, 8'h00, 8'h00);
    send_item(tac_pkg::CMD_STEP, 8'hFF, 8'hFF);
    send_item(CMD_UNUSED, 8'hFF, 8'hFF);
  endtask

  task automatic test_opcodes();
    logic [7:0] prog [13];
    prog = '{tac_pkg::OP_LDI, 8'hFF, 8'h01, tac_pkg::OP_LDB, 8'h80, tac_pkg::OP_ADD,
             tac_pkg::OP_BEEP, tac_pkg::OP_STORE, 8'hFF, tac_pkg::OP_PRINT, 8'hFF, 8'hFF,
             tac_pkg::OP_HALT};
    foreach (prog[i]) send_item(tac_pkg::CMD_LOAD, tac_pkg::START_RESET + 8'(i), prog[i]);
    send_item(tac_pkg::CMD_RESTART, 8'h00, 8'h00);
    repeat (9) send_item(tac_pkg::CMD_STEP, 8'(items_sent), 8'h00);
  endtask

  task automatic test_ceiling_and_wrap();
    // ceiling at zero halts on the very first fetch
    drain();
    write_regs(8'd1, 8'd0);
    send_item(tac_pkg::CMD_RESTART, 8'h00, 8'h00);
    send_item(tac_pkg::CMD_STEP, 8'h00, 8'h00);
    // load immediate at the top of memory: second operand wraps to the reserved byte
    drain();
    write_regs(8'd254, 8'd255);
    send_item(tac_pkg::CMD_LOAD, 8'd254, tac_pkg::OP_LDI);
    send_item(tac_pkg::CMD_LOAD, 8'd255, 8'h10);
    send_item(tac_pkg::CMD_RESTART, 8'h00, 8'h00);
    send_item(tac_pkg::CMD_STEP, 8'h00, 8'h00);
    send_item(tac_pkg::CMD_STEP, 8'h00, 8'h00);
  endtask

  task automatic test_random_programs();
    int         phase;
    int         plen;
    int         k;
    logic [7:0] wr_addr;
    logic [7:0] op;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase % 8 == 0) begin
        drain();
        write_regs(pick_start(), pick_ceiling());
      end
      send_item(tac_pkg::CMD_RESTART, 8'($urandom), 8'($urandom));
      wr_addr = start_m;
      plen    = $urandom_range(2, 14);
      k       = 0;
      while (k < plen) begin
        op = pick_opcode();
        send_item(tac_pkg::CMD_LOAD, wr_addr, op);
        wr_addr++;
        k++;
        repeat (operand_bytes(op)) begin
          send_item(tac_pkg::CMD_LOAD, wr_addr, pick_operand(op));
          wr_addr++;
          k++;
        end
      end
      repeat ($urandom_range(1, plen + 3)) begin
        if ($urandom_range(0, 9) == 0)
          send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
        else
          send_item(tac_pkg::CMD_STEP, 8'($urandom), 8'($urandom));
      end
      phase++;
    end
  endtask

  initial begin
    foreach (mem_img[i]) mem_img[i] = '0;
    pc_m   = {1'b0, tac_pkg::START_RESET};
    acc_m  = '0;
    opr_m  = '0;
    halt_m = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_opcodes();
    test_ceiling_and_wrap();
    test_random_programs();
    drain();
    $display("Sent %0d command items, %0d of them instruction steps, under %0d register settings.",
             items_sent, steps_sent, cfg_sets + 1);
    $display("Checked %0d results field by field; %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results outstanding", pending_cpu_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
src/tac_pkg.sv
src/tac_ram.sv
src/tac_mem.sv
src/tiny_accumulator_cpu_step.sv
tb/tb.sv
